FILE: src/pwlm_pkg.sv
// shared types, codes and reset defaults for the piecewise linear pixel map
package pwlm_pkg;

  localparam int MaxSegmentsDflt = 8;
  localparam int FracBitsDflt    = 8;
  localparam int DfltCount       = 3;
  localparam int SumW            = 26;

  typedef enum logic [1:0] {
    FUNC_MAP    = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef struct packed {
    logic        [7:0]  start;
    logic signed [15:0] slope;
    logic signed [18:0] offset;
  } seg_t;

  typedef struct packed {
    logic       ins_ok;
    logic       rm_ok;
    seg_t       new_seg;
    logic [7:0] pixel;
    logic [2:0] rm_idx;
  } cmd_t;

  function automatic seg_t dflt_seg(int idx);
    seg_t s;
    s = '0;
    case (idx)
      0: begin
        s.slope = 16'sd256;
      end
      1: begin
        s.start  = 8'd100;
        s.slope  = 16'sd256;
        s.offset = 19'sd12800;
      end
      2: begin
        s.start = 8'd200;
        s.slope = 16'sd256;
      end
      default: ;
    endcase
    return s;
  endfunction

endpackage

FILE: src/pwlm_cell.sv
// one table slot: holds a segment, shifts with its neighbors, joins the select chain
module pwlm_cell #(
  parameter int INDEX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pwlm_pkg::cmd_t cmd_i,
  input  pwlm_pkg::seg_t left_seg_i,
  input  logic           left_ge_i,
  input  logic           left_valid_i,
  input  pwlm_pkg::seg_t right_seg_i,
  input  logic           right_valid_i,
  input  pwlm_pkg::seg_t sel_i,
  output pwlm_pkg::seg_t sel_o,
  output pwlm_pkg::seg_t seg_o,
  output logic           ge_o,
  output logic           valid_o,
  output logic           hit_o
);
  import pwlm_pkg::*;

  seg_t seg_q, seg_d;
  logic valid_q, valid_d;
  logic lt;

  assign ge_o    = valid_q && (seg_q.start <= cmd_i.new_seg.start);
  assign lt      = valid_q && (seg_q.start < cmd_i.pixel);
  assign sel_o   = lt ? seg_q : sel_i;
  assign hit_o   = valid_q && (INDEX == int'(cmd_i.rm_idx));
  assign seg_o   = seg_q;
  assign valid_o = valid_q;

  always_comb begin
    seg_d   = seg_q;
    valid_d = valid_q;
    if (cmd_i.ins_ok) begin
      valid_d = left_valid_i;
      if (!ge_o) begin
        seg_d = left_ge_i ? cmd_i.new_seg : left_seg_i;
      end
    end else if (cmd_i.rm_ok && (INDEX >= int'(cmd_i.rm_idx))) begin
      seg_d   = right_seg_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q   <= dflt_seg(INDEX);
      valid_q <= (INDEX < DfltCount);
    end else begin
      seg_q   <= seg_d;
      valid_q <= valid_d;
    end
  end

endmodule

FILE: src/piecewise_linear_pixel_map_top.sv
// top level of the piecewise linear pixel map: cell row, select stage and arithmetic stage
// The segment table lives in a row of cells, one segment per cell, kept sorted by start.
// Map, insert and remove transactions are taken one per clock, with no bubbles, unless the
// output stalls; a result goes via stage one to the output register. Inserts and removes edit
// the row in the cycle they are accepted, so the next transaction already sees the new table.
// Segment selection runs as one compare per cell and a select chain along the row; the
// second stage holds one 16 x 9 multiply, the offset add, the floor and the clamp.
module piecewise_linear_pixel_map_top #(
  parameter int MAX_SEGMENTS = pwlm_pkg::MaxSegmentsDflt,
  parameter int FRAC_BITS    = pwlm_pkg::FracBitsDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_in[7:0], seg_start[15:8], seg_slope[31:16], seg_offset[50:32],
  // remove_index[53:51], zero fill
  input  logic [55:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_out[7:0], status[8], segment_count[12:9], zero fill
  output logic [15:0] m_axis_tdata
);
  import pwlm_pkg::*;

  localparam int N  = MAX_SEGMENTS;
  localparam int CW = $clog2(N + 1);
  localparam logic [CW-1:0] CntRst = CW'((N < DfltCount) ? N : DfltCount);

  cmd_t          cmd;
  func_e         op;
  logic          accept;
  logic          adv_out;
  seg_t          seg_w   [N];
  seg_t          sel_w   [N+1];
  logic [N-1:0]  ge_w;
  logic [N-1:0]  valid_w;
  logic [N-1:0]  hit_w;
  logic          full;
  logic          rm_hit;
  logic          status;

  logic [CW-1:0] count_q, count_d;
  logic          s1_valid_q, out_valid_q;
  logic          s1_map_q;
  logic [7:0]    s1_px_q;
  seg_t          s1_seg_q;
  logic          s1_status_q;
  logic [3:0]    s1_count_q;
  logic [7:0]    out_pix_q;
  logic          out_status_q;
  logic [3:0]    out_count_q;

  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] shifted;
  logic [7:0]             pix;

  assign op      = func_e'(s_axis_tuser);
  assign adv_out = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv_out;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign full    = valid_w[N-1];
  assign rm_hit  = |hit_w;

  assign cmd.new_seg.start  = s_axis_tdata[15:8];
  assign cmd.new_seg.slope  = s_axis_tdata[31:16];
  assign cmd.new_seg.offset = s_axis_tdata[50:32];
  assign cmd.pixel          = s_axis_tdata[7:0];
  assign cmd.rm_idx         = s_axis_tdata[53:51];
  assign cmd.ins_ok         = accept && (op == FUNC_INSERT) && !full;
  assign cmd.rm_ok          = accept && (op == FUNC_REMOVE) && rm_hit;

  assign sel_w[0] = seg_w[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    seg_t left_seg, right_seg;
    logic left_ge, left_valid, right_valid;
    if (i == 0) begin : g_first
      assign left_seg   = '0;
      assign left_ge    = 1'b1;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_seg   = seg_w[i-1];
      assign left_ge    = ge_w[i-1];
      assign left_valid = valid_w[i-1];
    end
    if (i == N - 1) begin : g_last
      assign right_seg   = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_seg   = seg_w[i+1];
      assign right_valid = valid_w[i+1];
    end
    pwlm_cell #(
      .INDEX(i)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i         (cmd),
      .left_seg_i    (left_seg),
      .left_ge_i     (left_ge),
      .left_valid_i  (left_valid),
      .right_seg_i   (right_seg),
      .right_valid_i (right_valid),
      .sel_i         (sel_w[i]),
      .sel_o         (sel_w[i+1]),
      .seg_o         (seg_w[i]),
      .ge_o          (ge_w[i]),
      .valid_o       (valid_w[i]),
      .hit_o         (hit_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins_ok) begin
      count_d = count_q + CW'(1);
    end else if (cmd.rm_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    unique case (op)
      FUNC_MAP:    status = 1'b0;
      FUNC_INSERT: status = full;
      FUNC_REMOVE: status = !rm_hit;
      default:     status = 1'b1;
    endcase
  end

  assign sum     = SumW'(s1_seg_q.slope) * SumW'($signed({1'b0, s1_px_q}))
                 + SumW'(s1_seg_q.offset);
  assign shifted = sum >>> FRAC_BITS;

  always_comb begin
    if (!s1_map_q || (sum < 0)) begin
      pix = 8'd0;
    end else if (shifted > SumW'(255)) begin
      pix = 8'd255;
    end else begin
      pix = shifted[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= CntRst;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (adv_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_map_q    <= (op == FUNC_MAP) && valid_w[0];
      s1_px_q     <= cmd.pixel;
      s1_seg_q    <= sel_w[N];
      s1_status_q <= status;
      s1_count_q  <= 4'(7'(count_d));
    end
    if (adv_out && s1_valid_q) begin
      out_pix_q    <= pix;
      out_status_q <= s1_status_q;
      out_count_q  <= s1_count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_status_q, out_pix_q};

  a_count_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(count_q))
    else $error("segment count disagrees with occupied cells");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= N)
    else $error("segment count above table size");

  a_reject_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q |-> out_pix_q == 8'd0)
    else $error("rejected transaction carries a nonzero pixel");

  a_edit_only_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("table changed without an input transaction");

endmodule
